>>> rtl/core/dpcr_pkg.sv
// dpcr_pkg: shared constants, register indexes and sequencer states for the
// dma page chunk resolver core. No dependencies.
`default_nettype none

package dpcr_pkg;

  // page geometry
  localparam int PAGE_BYTES = 2048;
  localparam int PAGE_BITS  = 11;

  // default sizing
  localparam int DEF_MAX_BANKS = 8;
  localparam int DEF_MAX_BYTES = 61440;

  // field widths
  localparam int ADDR_W  = 64;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 16;
  localparam int CHUNK_W = 12;
  localparam int INDEX_W = 6;
  localparam int ENTRY_W = 3;
  localparam int BCNT_W  = 4;
  localparam int DIVCNT_W = 5;

  // stream widths (tdata padded to whole bytes)
  localparam int S_TDATA_W = 184;
  localparam int M_TDATA_W = 208;

  // configuration register indexes
  localparam logic CFG_BANK_COUNT = 1'b0;
  localparam logic CFG_HOST_COORD = 1'b1;

  localparam logic [BCNT_W-1:0] BANK_COUNT_RESET = 4'd8;

  // request kinds on tuser
  localparam logic FUNC_TABLE_WRITE = 1'b0;
  localparam logic FUNC_COPY        = 1'b1;

  // last chunk index before the result limit
  localparam logic [INDEX_W-1:0] INDEX_LIMIT = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHUNK,
    ST_SIDE,
    ST_DIV,
    ST_STORE,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/dma_page_chunk_resolver_core.sv
// dma_page_chunk_resolver_core: splits a copy request into page-safe chunks
// and resolves both endpoints. Depends on dpcr_pkg.
`default_nettype none

// One request is taken at a time; s_axis_tready is high only while the core
// is idle. A table write and an empty copy are done when taken; an oversized
// copy goes straight to its rejected result. Each chunk of a copy is set up in
// ST_CHUNK, then each endpoint is resolved in ST_SIDE, directly for an endpoint
// outside striped DRAM or through ST_DIV and ST_STORE for an endpoint in
// striped DRAM: page / bank_count runs on one shared restoring divider that
// makes one quotient bit per cycle, used first for the source and then for the
// destination. The chunk then waits in ST_OUT until the output takes it.
// Configuration writes are taken at any time but must only be issued while
// the core is idle.
module dma_page_chunk_resolver_core
  import dpcr_pkg::*;
#(
  parameter int MAX_BANKS = DEF_MAX_BANKS,
  parameter int MAX_BYTES = DEF_MAX_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,

  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // entry_index, entry_value, src_addr, dst_addr, byte_count, zero pad
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // func
  input  wire logic                 s_axis_tuser,

  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // src_local, src_middle, src_coord, dst_local, dst_middle, dst_coord,
  // chunk_bytes, owner_engine, realign, zero pad
  output      logic [M_TDATA_W-1:0] m_axis_tdata,
  // rejected
  output      logic                 m_axis_tuser,
  output      logic                 m_axis_tlast
);

  localparam int BANK_W = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;

  // input field slices
  logic [ENTRY_W-1:0] in_entry_index;
  logic [WORD_W-1:0]  in_entry_value;
  logic [ADDR_W-1:0]  in_src_addr;
  logic [ADDR_W-1:0]  in_dst_addr;
  logic [COUNT_W-1:0] in_byte_count;

  assign in_entry_index = s_axis_tdata[2:0];
  assign in_entry_value = s_axis_tdata[34:3];
  assign in_src_addr    = s_axis_tdata[98:35];
  assign in_dst_addr    = s_axis_tdata[162:99];
  assign in_byte_count  = s_axis_tdata[178:163];

  state_t state;
  state_t state_next;

  // configuration and table
  logic [BCNT_W-1:0] bank_count;
  logic [WORD_W-1:0] host_coord;
  logic [WORD_W-1:0] bank_coord [MAX_BANKS];

  // request and walk registers
  logic [ADDR_W-1:0]   src_addr;
  logic [ADDR_W-1:0]   dst_addr;
  logic [COUNT_W-1:0]  size;
  logic [COUNT_W-1:0]  offset;
  logic [INDEX_W-1:0]  index;
  logic [CHUNK_W-1:0]  chunk;
  logic                side;
  logic [ADDR_W-1:0]   sum;

  // shared divider
  logic [DIVCNT_W-1:0] div_cnt;
  logic [WORD_W-1:0]   quo;
  logic [4:0]          rem;

  // result registers
  logic [WORD_W-1:0]  src_local, src_middle, src_coord;
  logic [WORD_W-1:0]  dst_local, dst_middle, dst_coord;
  logic               rejected;
  logic               last;

  // handshakes
  logic in_accept;
  logic out_accept;
  logic is_copy;
  logic is_empty;
  logic is_oversize;

  assign in_accept   = s_axis_tvalid && s_axis_tready;
  assign out_accept  = m_axis_tvalid && m_axis_tready;
  assign is_copy     = (s_axis_tuser == FUNC_COPY);
  assign is_empty    = (in_byte_count == '0);
  assign is_oversize = (32'(in_byte_count) > MAX_BYTES);

  // bank count clamped to 1..MAX_BANKS
  logic [4:0] eff_banks;
  always_comb begin
    if (bank_count == '0) begin
      eff_banks = 5'd1;
    end else if (32'(bank_count) > MAX_BANKS) begin
      eff_banks = 5'(MAX_BANKS);
    end else begin
      eff_banks = {1'b0, bank_count};
    end
  end

  // chunk bounds
  logic [COUNT_W-1:0] remaining;
  logic [CHUNK_W-1:0] chunk_first;
  logic [CHUNK_W-1:0] room;
  logic [CHUNK_W-1:0] chunk_clip;
  logic [COUNT_W-1:0] offset_adv;
  logic               last_chunk;
  logic               side_dram;
  logic               side_host;

  assign remaining   = size - offset;
  assign chunk_first = (remaining > COUNT_W'(PAGE_BYTES)) ? CHUNK_W'(PAGE_BYTES)
                                                          : remaining[CHUNK_W-1:0];
  assign room        = CHUNK_W'(PAGE_BYTES) - {1'b0, sum[PAGE_BITS-1:0]};
  assign chunk_clip  = (chunk > room) ? room : chunk;
  assign offset_adv  = offset + COUNT_W'(chunk);
  assign last_chunk  = (offset_adv >= size) || (index == INDEX_LIMIT);
  assign side_dram   = sum[ADDR_W-1];
  assign side_host   = (sum[ADDR_W-2:ADDR_W-4] != '0);

  // restoring divide step
  logic [5:0] rem_shift;
  logic [5:0] rem_sub;
  logic       rem_ge;
  logic [4:0] rem_next;

  assign rem_shift = {rem, quo[WORD_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, eff_banks});
  assign rem_sub   = rem_shift - {1'b0, eff_banks};
  assign rem_next  = rem_ge ? rem_sub[4:0] : rem_shift[4:0];

  // resolved dram endpoint from quotient and remainder
  logic [WORD_W-1:0] dram_local;
  logic [WORD_W-1:0] dram_coord;
  assign dram_local = {quo[WORD_W-PAGE_BITS-1:0], sum[PAGE_BITS-1:0]};
  assign dram_coord = bank_coord[rem[BANK_W-1:0]];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && is_copy && !is_empty) begin
          state_next = is_oversize ? ST_OUT : ST_CHUNK;
        end
      end
      ST_CHUNK: state_next = ST_SIDE;
      ST_SIDE: begin
        if (side_dram) begin
          state_next = ST_DIV;
        end else begin
          state_next = side ? ST_OUT : ST_SIDE;
        end
      end
      ST_DIV: begin
        if (div_cnt == '1) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: state_next = side ? ST_OUT : ST_SIDE;
      ST_OUT: begin
        if (out_accept) begin
          state_next = last ? ST_IDLE : ST_CHUNK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_OUT:  m_axis_tvalid = 1'b1;
      default: begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers and coordinate table
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_count <= BANK_COUNT_RESET;
      host_coord <= '0;
      for (int i = 0; i < MAX_BANKS; i++) begin
        bank_coord[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BANK_COUNT: bank_count <= cfg_data[BCNT_W-1:0];
          CFG_HOST_COORD: host_coord <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept && (s_axis_tuser == FUNC_TABLE_WRITE) &&
          (32'(in_entry_index) < MAX_BANKS)) begin
        bank_coord[BANK_W'(in_entry_index)] <= in_entry_value;
      end
    end
  end

  // walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
      index  <= '0;
    end else if (state == ST_OUT && out_accept) begin
      if (last) begin
        offset <= '0;
        index  <= '0;
      end else begin
        offset <= offset_adv;
        index  <= index + INDEX_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_accept && is_copy) begin
          src_addr <= in_src_addr;
          dst_addr <= in_dst_addr;
          size     <= in_byte_count;
          rejected <= is_oversize;
          last     <= is_oversize;
          if (is_oversize) begin
            src_local  <= '0;
            src_middle <= '0;
            src_coord  <= '0;
            dst_local  <= '0;
            dst_middle <= '0;
            dst_coord  <= '0;
            chunk      <= '0;
          end
        end
      end
      ST_CHUNK: begin
        chunk <= chunk_first;
        sum   <= src_addr + ADDR_W'(offset);
        side  <= 1'b0;
      end
      ST_SIDE: begin
        if (side_dram) begin
          chunk   <= chunk_clip;
          quo     <= sum[PAGE_BITS+WORD_W-1:PAGE_BITS];
          rem     <= '0;
          div_cnt <= '0;
        end else begin
          if (side) begin
            dst_local  <= sum[WORD_W-1:0];
            dst_middle <= side_host ? sum[ADDR_W-1:WORD_W] : '0;
            dst_coord  <= side_host ? host_coord : sum[ADDR_W-1:WORD_W];
            last       <= last_chunk;
          end else begin
            src_local  <= sum[WORD_W-1:0];
            src_middle <= side_host ? sum[ADDR_W-1:WORD_W] : '0;
            src_coord  <= side_host ? host_coord : sum[ADDR_W-1:WORD_W];
            sum        <= dst_addr + ADDR_W'(offset);
            side       <= 1'b1;
          end
        end
      end
      ST_DIV: begin
        quo     <= {quo[WORD_W-2:0], rem_ge};
        rem     <= rem_next;
        div_cnt <= div_cnt + DIVCNT_W'(1);
      end
      ST_STORE: begin
        if (side) begin
          dst_local  <= dram_local;
          dst_middle <= '0;
          dst_coord  <= dram_coord;
          last       <= last_chunk;
        end else begin
          src_local  <= dram_local;
          src_middle <= '0;
          src_coord  <= dram_coord;
          sum        <= dst_addr + ADDR_W'(offset);
          side       <= 1'b1;
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  logic realign;
  assign realign = (src_local[5:0] != dst_local[5:0]);

  assign m_axis_tdata = {2'b00, realign, index[0], chunk,
                         dst_coord, dst_middle, dst_local,
                         src_coord, src_middle, src_local};
  assign m_axis_tuser = rejected;
  assign m_axis_tlast = last;

  // the core never takes a request while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request accepted while result pending");

  // a rejected result is always the only one
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("rejected result not marked last");

  // a normal chunk is never empty and never exceeds a page
  a_chunk_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |->
      (chunk != '0 && chunk <= CHUNK_W'(PAGE_BYTES)))
    else $error("chunk size out of range");

  // divider runs its full count before storing
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt != '1) |=> (state == ST_DIV))
    else $error("divider left early");

  // counters are back at zero whenever the core is idle
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (offset == '0 && index == '0))
    else $error("walk counters not cleared");

endmodule

`default_nettype wire
